FILE: rtl/text_encoding_guesser_core_assert.svh
// Assertion macros for the text encoding guesser core
`ifndef TEXT_ENCODING_GUESSER_CORE_ASSERT_SVH
`define TEXT_ENCODING_GUESSER_CORE_ASSERT_SVH

// hold consequent in the same cycle
`define TEG_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// hold consequent in the following cycle
`define TEG_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/teg_pkg.sv
// Shared types, constants and helper functions of the text encoding guesser
`default_nettype none

package teg_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam logic [1:0] ENC_UTF8      = 2'd0;
   localparam logic [1:0] ENC_SHIFT_JIS = 2'd1;
   localparam logic [1:0] ENC_LATIN1    = 2'd2;
   localparam logic [1:0] ENC_UNUSED    = 2'd3;

   localparam int BOM_LENGTH = 3;
   localparam logic [1:0] BOM_FULL = 2'd3;

   localparam logic [7:0] UTF8_LEAD_LOW  = 8'hC0;
   localparam logic [7:0] UTF8_LEAD_HIGH = 8'hFD;
   localparam logic [7:0] SJIS_TRAIL_LOW  = 8'h40;
   localparam logic [7:0] SJIS_TRAIL_HIGH = 8'hFC;
   localparam logic [7:0] KANA_LOW  = 8'hA1;
   localparam logic [7:0] KANA_HIGH = 8'hDF;
   localparam logic [7:0] SJIS_LEAD_A_LOW  = 8'h81;
   localparam logic [7:0] SJIS_LEAD_A_HIGH = 8'h9F;
   localparam logic [7:0] SJIS_LEAD_B_LOW  = 8'hE0;
   localparam logic [7:0] SJIS_LEAD_B_HIGH = 8'hEF;
   localparam logic [7:0] SJIS_BAD_FROM = 8'hF0;
   localparam logic [7:0] SJIS_BAD_A    = 8'h80;
   localparam logic [7:0] SJIS_BAD_B    = 8'hA0;

   localparam logic [3:0] OWED_MAX = 4'hF;
   localparam logic [1:0] DOUBLE_LEAD_MAX = 2'd3;
   localparam int KANA_SHIFT_HIGH = 4;
   localparam int KANA_SHIFT_LOW  = 2;
   localparam int KANA_GROWTH     = 5;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } teg_req_type;

   typedef struct packed {
      logic [1:0] encoding_code;
   } teg_rsp_type;

   function automatic logic [7:0] bom_byte(input logic [1:0] idx);
      logic [7:0] result;
      case (idx)
         2'd0:    result = 8'hEF;
         2'd1:    result = 8'hBB;
         2'd2:    result = 8'hBF;
         default: result = 8'h00;
      endcase
      return result;
   endfunction

   // ones below the top bit, counted from bit 6 downwards until the first zero
   function automatic logic [2:0] lead_ones(input logic [6:0] bits);
      logic [2:0] count;
      logic       run;
      count = 3'd0;
      run   = 1'b1;
      for (int i = 6; i >= 0; i--) begin
         run = run & bits[i];
         if (run) begin
            count = count + 3'd1;
         end
      end
      return count;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/teg_stream_if.sv
// Valid/ready stream interface carrying one word per handshake
`default_nettype none

interface teg_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/text_encoding_guesser_core.sv
// Top level of the text encoding guesser: word registers, config and verdict output.
// A last byte's verdict is written to the verdict register when its word leaves the input register.
// Throughput: one word per cycle while no last-byte word waits in the input register.
// A last-byte word waits in the input register only while the verdict register is full and not being read.
// Reset (synchronous, active high) empties both registers, clears the trackers
// and clears the Shift_JIS preference bit.
`default_nettype none

module text_encoding_guesser_core #(
   parameter int COUNT_WIDTH = teg_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   teg_stream_if.sink   req_stream,
   teg_stream_if.source rsp_stream,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data
);
   import teg_pkg::*;

   logic        assume_ff;
   logic        s1_valid_ff;
   teg_req_type s1_word_ff;
   logic        out_valid_ff;
   logic [1:0]  out_code_ff;

   logic        out_free;
   logic        advance;
   logic [1:0]  code_in;

   assign out_free = !out_valid_ff || rsp_stream.ready;
   assign advance  = s1_valid_ff && (!s1_word_ff.last_byte || out_free);

   assign req_stream.ready = !s1_valid_ff || advance;
   assign rsp_stream.valid = out_valid_ff;
   assign rsp_stream.payload.encoding_code = out_code_ff;

   teg_tracker #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_tracker (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .step          (s1_word_ff),
      .sjis_forced   (assume_ff),
      .encoding_code (code_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         assume_ff <= 1'b0;
      end else if (csr_write_enable) begin
         assume_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_stream.ready) begin
         s1_valid_ff <= req_stream.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_stream.ready && req_stream.valid) begin
         s1_word_ff <= req_stream.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && s1_word_ff.last_byte) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_stream.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_word_ff.last_byte) begin
         out_code_ff <= code_in;
      end
   end

`include "text_encoding_guesser_core_assert.svh"

   `TEG_ASSERT_NOW(a_code_defined, clock, reset, out_valid_ff, out_code_ff != ENC_UNUSED, "reserved encoding code on output")
   `TEG_ASSERT_NEXT(a_no_spurious_word, clock, reset, !out_valid_ff && !(s1_valid_ff && s1_word_ff.last_byte), !out_valid_ff, "verdict without a last byte")
   `TEG_ASSERT_NOW(a_stall_cause, clock, reset, s1_valid_ff && !advance, out_valid_ff && !rsp_stream.ready && s1_word_ff.last_byte, "input register stalled without a full verdict register")

endmodule

`default_nettype wire

FILE: rtl/teg_tracker.sv
// Per-buffer state trackers and verdict logic of the encoding guesser
`default_nettype none

module teg_tracker #(
   parameter int COUNT_WIDTH = teg_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire teg_pkg::teg_req_type step,
   input  wire logic                sjis_forced,
   output logic [1:0]               encoding_code
);
   import teg_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
   localparam int WideWidth = COUNT_WIDTH + KANA_GROWTH;

   logic [3:0]             owed_ff, owed_in;
   logic                   utf8_ok_ff, utf8_ok_in;
   logic                   utf8_start_ff, utf8_start_in;
   logic                   sjis_ok_ff, sjis_ok_in;
   logic                   pending_ff, pending_in;
   logic [1:0]             dlead_ff, dlead_in;
   logic [COUNT_WIDTH-1:0] kana_ff, kana_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             bom_stage_ff, bom_stage_in;
   logic                   bom_broken_ff, bom_broken_in;

   logic [7:0]           b;
   logic [4:0]           owed_sum;
   logic                 lead;
   logic [WideWidth-1:0] kana_wide;
   logic [WideWidth-1:0] kana_x20;
   logic [WideWidth-1:0] count_wide;

   assign b = step.byte_value;

   always_comb begin
      owed_in       = owed_ff;
      utf8_ok_in    = utf8_ok_ff;
      utf8_start_in = utf8_start_ff;
      sjis_ok_in    = sjis_ok_ff;
      dlead_in      = dlead_ff;
      kana_in       = kana_ff;
      bom_stage_in  = bom_stage_ff;
      bom_broken_in = bom_broken_ff;
      owed_sum      = {1'b0, owed_ff} + {2'b00, lead_ones(b[6:0])};

      if (count_ff < COUNT_WIDTH'(BOM_LENGTH) && !bom_broken_ff) begin
         if (b == bom_byte(count_ff[1:0])) begin
            bom_stage_in = bom_stage_ff + 2'd1;
         end else begin
            bom_broken_in = 1'b1;
         end
      end

      if (b[7:6] == 2'b10) begin
         if (owed_ff != 4'd0) begin
            owed_in = owed_ff - 4'd1;
         end
      end else begin
         if (owed_ff != 4'd0) begin
            utf8_ok_in = 1'b0;
         end
         if (b >= UTF8_LEAD_LOW && b <= UTF8_LEAD_HIGH) begin
            utf8_start_in = 1'b1;
            owed_in = (owed_sum > {1'b0, OWED_MAX}) ? OWED_MAX : owed_sum[3:0];
         end
      end

      if (pending_ff) begin
         if (b < SJIS_TRAIL_LOW || b > SJIS_TRAIL_HIGH) begin
            sjis_ok_in = 1'b0;
         end else if (dlead_ff != DOUBLE_LEAD_MAX) begin
            dlead_in = dlead_ff + 2'd1;
         end
      end else begin
         if (b >= KANA_LOW && b <= KANA_HIGH && kana_ff != CountMax) begin
            kana_in = kana_ff + COUNT_WIDTH'(1);
         end
         if (b >= SJIS_BAD_FROM || b == SJIS_BAD_A || b == SJIS_BAD_B) begin
            sjis_ok_in = 1'b0;
         end
      end

      lead = (b >= SJIS_LEAD_A_LOW && b <= SJIS_LEAD_A_HIGH) ||
             (b >= SJIS_LEAD_B_LOW && b <= SJIS_LEAD_B_HIGH);
      pending_in = lead && !pending_ff;
      if (pending_in && step.last_byte) begin
         sjis_ok_in = 1'b0;
      end

      count_in = (count_ff != CountMax) ? count_ff + COUNT_WIDTH'(1) : count_ff;

      kana_wide  = WideWidth'(kana_in);
      count_wide = WideWidth'(count_in);
      kana_x20   = (kana_wide << KANA_SHIFT_HIGH) + (kana_wide << KANA_SHIFT_LOW);

      if (count_in > COUNT_WIDTH'(BOM_LENGTH) && bom_stage_in == BOM_FULL) begin
         encoding_code = ENC_UTF8;
      end else if (sjis_ok_in && sjis_forced) begin
         encoding_code = ENC_SHIFT_JIS;
      end else if (utf8_ok_in && owed_in == 4'd0 && utf8_start_in) begin
         encoding_code = ENC_UTF8;
      end else if (sjis_ok_in && (dlead_in == DOUBLE_LEAD_MAX || kana_x20 > count_wide)) begin
         encoding_code = ENC_SHIFT_JIS;
      end else begin
         encoding_code = ENC_LATIN1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && step.last_byte)) begin
         owed_ff       <= 4'd0;
         utf8_ok_ff    <= 1'b1;
         utf8_start_ff <= 1'b0;
         sjis_ok_ff    <= 1'b1;
         pending_ff    <= 1'b0;
         dlead_ff      <= 2'd0;
         kana_ff       <= '0;
         count_ff      <= '0;
         bom_stage_ff  <= 2'd0;
         bom_broken_ff <= 1'b0;
      end else if (advance) begin
         owed_ff       <= owed_in;
         utf8_ok_ff    <= utf8_ok_in;
         utf8_start_ff <= utf8_start_in;
         sjis_ok_ff    <= sjis_ok_in;
         pending_ff    <= pending_in;
         dlead_ff      <= dlead_in;
         kana_ff       <= kana_in;
         count_ff      <= count_in;
         bom_stage_ff  <= bom_stage_in;
         bom_broken_ff <= bom_broken_in;
      end
   end

endmodule

`default_nettype wire

FILE: tb/encoding_verdict_checker.sv
// Checker for the text encoding guesser: tracks each buffer and compares every verdict word
`timescale 1ns / 100ps

module encoding_verdict_checker #(
   parameter int COUNT_WIDTH = teg_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  teg_pkg::teg_req_type  req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  teg_pkg::teg_rsp_type  rsp_word,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data,
   output int                    mismatch_count,
   output int                    verdicts_owed
);
   import teg_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;
   localparam logic [23:0] MARK_SEQ = 24'hEFBBBF;

   logic                   assume_sjis;
   logic [3:0]             owed;
   logic                   utf8_intact;
   logic                   utf8_lead_seen;
   logic                   sjis_intact;
   logic                   trail_due;
   logic [1:0]             pair_count;
   logic [COUNT_WIDTH-1:0] kana_count;
   logic [COUNT_WIDTH-1:0] byte_total;
   logic [1:0]             mark_stage;
   logic                   mark_broken;
   logic [1:0]             verdict_queue [$];

   task automatic clear_tracker();
      owed           = '0;
      utf8_intact    = 1'b1;
      utf8_lead_seen = 1'b0;
      sjis_intact    = 1'b1;
      trail_due      = 1'b0;
      pair_count     = '0;
      kana_count     = '0;
      byte_total     = '0;
      mark_stage     = '0;
      mark_broken    = 1'b0;
   endtask

   // fold one byte into the tracker; on the last byte give the verdict and clear
   task automatic absorb_byte(input logic [7:0] b, input logic last,
                              output logic emit, output logic [1:0] code);
      logic pending;
      logic run;
      logic is_lead;
      pending = trail_due;
      code    = ENC_LATIN1;
      if (byte_total < 3 && !mark_broken) begin
         if (b == MARK_SEQ[8 * (2 - byte_total[1:0]) +: 8]) begin
            mark_stage = mark_stage + 2'd1;
         end else begin
            mark_broken = 1'b1;
         end
      end
      if (b >= 8'h80 && b <= 8'hBF) begin
         if (owed != 0) begin
            owed = owed - 4'd1;
         end
      end else begin
         if (owed != 0) begin
            utf8_intact = 1'b0;
         end
         if (b >= UTF8_LEAD_LOW && b <= UTF8_LEAD_HIGH) begin
            utf8_lead_seen = 1'b1;
            run = 1'b1;
            for (int i = 6; i >= 0; i--) begin
               run = run & b[i];
               if (run && owed != OWED_MAX) begin
                  owed = owed + 4'd1;
               end
            end
         end
      end
      if (pending) begin
         if (b < SJIS_TRAIL_LOW || b > SJIS_TRAIL_HIGH) begin
            sjis_intact = 1'b0;
         end else if (pair_count != DOUBLE_LEAD_MAX) begin
            pair_count = pair_count + 2'd1;
         end
      end
      if (!pending && b >= KANA_LOW && b <= KANA_HIGH && kana_count != COUNT_TOP) begin
         kana_count = kana_count + 1'b1;
      end
      if (!pending && (b >= SJIS_BAD_FROM || b == SJIS_BAD_A || b == SJIS_BAD_B)) begin
         sjis_intact = 1'b0;
      end
      is_lead = (b >= SJIS_LEAD_A_LOW && b <= SJIS_LEAD_A_HIGH) ||
                (b >= SJIS_LEAD_B_LOW && b <= SJIS_LEAD_B_HIGH);
      if (is_lead && !pending) begin
         trail_due = 1'b1;
         if (last) begin
            sjis_intact = 1'b0;
         end
      end else begin
         trail_due = 1'b0;
      end
      if (byte_total != COUNT_TOP) begin
         byte_total = byte_total + 1'b1;
      end
      emit = last;
      if (last) begin
         if (byte_total > 3 && mark_stage == BOM_FULL) begin
            code = ENC_UTF8;
         end else if (sjis_intact && assume_sjis) begin
            code = ENC_SHIFT_JIS;
         end else if (utf8_intact && owed == 0 && utf8_lead_seen) begin
            code = ENC_UTF8;
         end else if (sjis_intact && (pair_count == DOUBLE_LEAD_MAX ||
                      40'(kana_count) * 40'd20 > 40'(byte_total))) begin
            code = ENC_SHIFT_JIS;
         end else begin
            code = ENC_LATIN1;
         end
         clear_tracker();
      end
   endtask

   always @(posedge clock) begin
      logic       emit;
      logic [1:0] code;
      logic [1:0] wanted;
      if (reset) begin
         mismatch_count = 0;
         assume_sjis = 1'b0;
         clear_tracker();
         verdict_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               $error("encoding_code expected none actual %0d", rsp_word.encoding_code);
               mismatch_count++;
            end else begin
               wanted = verdict_queue.pop_front();
               if (rsp_word.encoding_code !== wanted) begin
                  $error("encoding_code expected %0d actual %0d", wanted,
                         rsp_word.encoding_code);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable) begin
            assume_sjis = csr_write_data;
         end
         if (req_valid && req_ready) begin
            absorb_byte(req_word.byte_value, req_word.last_byte, emit, code);
            if (emit) begin
               verdict_queue.insert(verdict_queue.size(), code);
            end
         end
      end
      verdicts_owed = verdict_queue.size();
   end

endmodule

FILE: tb/testbench.sv
// Testbench top for the text encoding guesser core: stimulus, flow control and verdict
`timescale 1ns / 100ps

module testbench;
   import teg_pkg::*;

   localparam int CYCLE_LIMIT = 800000;
   localparam int PHASE_ITEMS = 150;
   localparam int DIRECTED_COUNT = 23;
   localparam logic [DIRECTED_COUNT*9-1:0] DIRECTED_WORDS = {
      9'h1FF,
      9'h181,
      9'h0EF, 9'h0BB, 9'h0BF, 9'h141,
      9'h0EF, 9'h0BB, 9'h1BF,
      9'h0C3, 9'h1A9,
      9'h0FD, 9'h0FD, 9'h1FD,
      9'h081, 9'h040, 9'h0E0, 9'h0FC, 9'h09F, 9'h13F,
      9'h0A1, 9'h100,
      9'h100
   };

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic       csr_write_data;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   logic       hold_request = 1'b0;
   int         hold_left = 0;
   int         mismatch_count;
   int         verdicts_owed;
   int         cycle_count = 0;
   int         phase_items;
   logic [7:0] buffer_bytes [$];

   teg_stream_if #(.payload_type(teg_req_type)) req_if ();
   teg_stream_if #(.payload_type(teg_rsp_type)) rsp_if ();

   text_encoding_guesser_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_stream       (req_if),
      .rsp_stream       (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   encoding_verdict_checker #(.COUNT_WIDTH(COUNT_WIDTH_DEFAULT)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_word         (req_if.payload),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_word         (rsp_if.payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .verdicts_owed    (verdicts_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 299;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("text_encoding_guesser_core regression: fail");
      $finish;
   end

   task automatic append_byte(input logic [7:0] b);
      buffer_bytes.insert(buffer_bytes.size(), b);
   endtask

   // enter and leave at a falling edge; hold the word until it is taken
   task automatic send_word(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= {b, last};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_buffer();
      for (int i = 0; i < buffer_bytes.size(); i++) begin
         send_word(buffer_bytes[i], i == buffer_bytes.size() - 1);
      end
      phase_items += buffer_bytes.size();
   endtask

   task automatic write_assume(input logic value);
      req_if.valid <= 1'b0;
      while (verdicts_owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic make_random_buffer();
      int         chars;
      logic [7:0] lead;
      buffer_bytes.delete();
      chars = ($urandom_range(19) == 0) ? $urandom_range(80, 40) : $urandom_range(8, 1);
      case ($urandom_range(9))
         0, 1, 2: begin
            if ($urandom_range(3) == 0) begin
               append_byte(8'hEF);
               append_byte(8'hBB);
               append_byte(8'hBF);
            end
            repeat (chars) begin
               case ($urandom_range(3))
                  0: append_byte(8'($urandom_range(8'h7F, 8'h00)));
                  1: begin
                     append_byte(8'($urandom_range(8'hDF, 8'hC2)));
                     append_byte(8'($urandom_range(8'hBF, 8'h80)));
                  end
                  2: begin
                     append_byte(8'($urandom_range(8'hEF, 8'hE0)));
                     repeat (2) append_byte(8'($urandom_range(8'hBF, 8'h80)));
                  end
                  default: begin
                     append_byte(8'($urandom_range(8'hF4, 8'hF0)));
                     repeat (3) append_byte(8'($urandom_range(8'hBF, 8'h80)));
                  end
               endcase
            end
         end
         3, 4, 5: begin
            repeat (chars) begin
               case ($urandom_range(2))
                  0: append_byte(8'($urandom_range(8'h7E, 8'h20)));
                  1: append_byte(8'($urandom_range(8'hDF, 8'hA1)));
                  default: begin
                     lead = $urandom_range(1) ? 8'($urandom_range(8'h9F, 8'h81))
                                              : 8'($urandom_range(8'hEF, 8'hE0));
                     append_byte(lead);
                     append_byte(8'($urandom_range(8'hFC, 8'h40)));
                  end
               endcase
            end
         end
         6: begin
            repeat (chars) begin
               append_byte(($urandom_range(3) == 0)
                           ? 8'($urandom_range(8'h7E, 8'h20))
                           : 8'($urandom_range(8'hDF, 8'hA1)));
            end
         end
         7: begin
            repeat (chars) append_byte(8'($urandom_range(8'hFF, 8'h80)));
            if ($urandom_range(1)) begin
               append_byte(8'($urandom_range(8'h9F, 8'h81)));
            end
         end
         default: begin
            repeat (chars) append_byte(8'($urandom_range(8'hFF, 8'h00)));
         end
      endcase
   endtask

   initial begin
      logic [8:0] word;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.payload   = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      phase_items      = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_assume(1'b0);
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         word = DIRECTED_WORDS[9 * (DIRECTED_COUNT - 1 - i) +: 9];
         send_word(word[7:0], word[8]);
      end

      for (int p = 0; p < 4; p++) begin
         write_assume(p % 2 == 1);
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 86; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 86; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            make_random_buffer();
            send_buffer();
         end
      end

      // hold the receiver off while short buffers keep coming
      write_assume(1'b1);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 1'b1;
      repeat (80) begin
         buffer_bytes.delete();
         repeat ($urandom_range(2, 1)) append_byte(8'($urandom_range(255)));
         send_buffer();
      end

      req_if.valid <= 1'b0;
      while (verdicts_owed != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("text_encoding_guesser_core regression: pass");
      end else begin
         $display("text_encoding_guesser_core regression: fail");
      end
      $finish;
   end

endmodule

FILE: text_encoding_guesser_core.f
+incdir+rtl
rtl/teg_pkg.sv
rtl/teg_stream_if.sv
rtl/teg_tracker.sv
rtl/text_encoding_guesser_core.sv
tb/encoding_verdict_checker.sv
tb/testbench.sv
